### rtl/smar_pkg.sv
// ----------------------------------------------------------------------------
// smar_pkg: shared types and constants for the shunt monitor auto-ranger
// Register indexes, reset values, device configuration byte layout and the
// beat structures passed between the pipeline stages.
// ----------------------------------------------------------------------------
package smar_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_USE_HALL      = 2'd0;
  localparam logic [1:0] REG_CURRENT_LEVEL = 2'd1;
  localparam logic [1:0] REG_VOLTAGE_LEVEL = 2'd2;
  localparam logic [1:0] REG_VOLTAGE_OFS   = 2'd3;

  localparam int CFG_DATA_W = 15;

  // reset values of the configuration registers
  localparam logic [14:0] CURRENT_LEVEL_RST = 15'd4000;
  localparam logic [12:0] VOLTAGE_LEVEL_RST = 13'd4000;
  localparam logic [12:0] VOLTAGE_OFS_RST   = 13'd10;

  // bus word layout
  localparam int BUS_READY_BIT = 1;
  localparam int BUS_VOLT_LSB  = 3;

  localparam logic [1:0] GAIN_MAX = 2'd3;

  // fixed bits of the device configuration high byte (bits 5..3 are live)
  localparam logic [2:0] CONF_LOW_BITS  = 3'b100;
  localparam logic [1:0] CONF_HIGH_BITS = 2'b00;

  typedef struct packed {
    logic [15:0]        bus_word;
    logic signed [15:0] shunt_reading;
    logic signed [15:0] hall_reading;
  } in_beat_t;

  typedef struct packed {
    logic        use_hall_current;
    logic [14:0] current_switch_level;
    logic [12:0] voltage_switch_level;
    logic [12:0] voltage_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] current_value;
    logic [12:0]        bus_voltage;
    logic               config_write;
    logic [7:0]         config_high_byte;
    logic [1:0]         gain_code;
    logic               voltage_range_high;
  } res_t;

endpackage

### rtl/smar_in.sv
// ----------------------------------------------------------------------------
// smar_in: input register stage
// Captures one input beat and hands it to the control stage. Beats whose
// ready bit is clear are dropped here without needing output space.
// ----------------------------------------------------------------------------
module smar_in (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  smar_pkg::in_beat_t in_beat,
  input  logic              out_free,
  output logic              fire,
  output smar_pkg::in_beat_t s1_beat
);

  logic               s1_valid_r;
  smar_pkg::in_beat_t s1_beat_r;
  logic               s1_rdy;
  logic               s1_take;

  assign s1_rdy   = s1_beat_r.bus_word[smar_pkg::BUS_READY_BIT];
  assign s1_take  = s1_valid_r & (~s1_rdy | out_free);
  assign in_stall = s1_valid_r & ~s1_take;
  assign fire     = s1_take & s1_rdy;
  assign s1_beat  = s1_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_beat_r <= in_beat;
    end
  end

endmodule

### rtl/smar_ctrl.sv
// ----------------------------------------------------------------------------
// smar_ctrl: gain and range auto-ranging control
// Holds the gain and range state with their hold-down counters and forms
// the result beat for the sample currently in the input register.
// ----------------------------------------------------------------------------
module smar_ctrl #(
  parameter int HOLD_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  smar_pkg::in_beat_t s1_beat,
  input  smar_pkg::cfg_t     cfg,
  output smar_pkg::res_t     res
);

  localparam int CW = $clog2(HOLD_COUNT + 1);
  localparam logic [CW-1:0] HOLD_V = CW'(HOLD_COUNT);

  logic [1:0]    gain_r, gain_nxt;
  logic [CW-1:0] gain_cnt_r, gain_cnt_nxt;
  logic          range_r, range_nxt;
  logic [CW-1:0] range_cnt_r, range_cnt_nxt;

  logic [12:0] volt;
  logic [15:0] shunt_u;
  logic [16:0] mag;
  logic [17:0] step_level;
  logic        wr;

  always_comb begin
    shunt_u    = s1_beat.shunt_reading;
    volt       = s1_beat.bus_word[15:smar_pkg::BUS_VOLT_LSB];
    // magnitude of the most negative code is 32768, hence 17 bits
    mag        = shunt_u[15] ? (17'h10000 - {1'b0, shunt_u}) : {1'b0, shunt_u};
    step_level = {3'b000, cfg.current_switch_level} << gain_r;

    gain_nxt      = gain_r;
    gain_cnt_nxt  = gain_cnt_r;
    range_nxt     = range_r;
    range_cnt_nxt = range_cnt_r;
    wr            = 1'b0;

    if (step_level <= {1'b0, mag} && gain_r < smar_pkg::GAIN_MAX) begin
      gain_nxt = gain_r + 2'd1;
      wr       = 1'b1;
    end
    if ({2'b00, cfg.current_switch_level} > mag) begin
      if (gain_cnt_r != '0) begin
        gain_cnt_nxt = gain_cnt_r - CW'(1);
        if (gain_cnt_r == CW'(1)) begin
          gain_nxt = 2'd0;
          wr       = 1'b1;
        end
      end
    end else begin
      gain_cnt_nxt = HOLD_V;
    end

    if (cfg.voltage_switch_level > volt) begin
      if (range_cnt_r != '0) begin
        range_cnt_nxt = range_cnt_r - CW'(1);
        // drop to 16 V, write requested even if already there
        if (range_cnt_r == CW'(1)) begin
          range_nxt = 1'b0;
          wr        = 1'b1;
        end
      end
    end else begin
      range_cnt_nxt = HOLD_V;
      if (!range_r) begin
        range_nxt = 1'b1;
        wr        = 1'b1;
      end
    end

    res.current_value      = cfg.use_hall_current ? s1_beat.hall_reading
                                                  : 16'(16'h0000 - shunt_u);
    res.bus_voltage        = (volt > cfg.voltage_offset) ? (volt - cfg.voltage_offset)
                                                         : 13'd0;
    res.config_write       = wr;
    res.config_high_byte   = {smar_pkg::CONF_HIGH_BITS, range_nxt, gain_nxt,
                              smar_pkg::CONF_LOW_BITS};
    res.gain_code          = gain_nxt;
    res.voltage_range_high = range_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= 2'd0;
      gain_cnt_r  <= HOLD_V;
      range_r     <= 1'b0;
      range_cnt_r <= HOLD_V;
    end else if (fire) begin
      gain_r      <= gain_nxt;
      gain_cnt_r  <= gain_cnt_nxt;
      range_r     <= range_nxt;
      range_cnt_r <= range_cnt_nxt;
    end
  end

endmodule

### rtl/smar_out.sv
// ----------------------------------------------------------------------------
// smar_out: result register
// Holds one result beat until the consumer takes it; accepts a new beat in
// the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module smar_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  smar_pkg::res_t res,
  output logic           out_free,
  output logic           out_valid,
  input  logic           out_stall,
  output smar_pkg::res_t out_res
);

  logic           out_valid_r;
  smar_pkg::res_t out_res_r;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

endmodule

### rtl/shunt_monitor_autorange.sv
// ----------------------------------------------------------------------------
// shunt_monitor_autorange: shunt/bus monitor with automatic gain and range
// Each beat passes the input register and then the result register.
// Throughput: 1 beat per cycle unless stalled; state updates per ready beat.
// Beats without the ready bit produce no result and leave state unchanged.
// Synchronous active-low reset clears control state and loads register
// defaults; no clearing pass, the block accepts beats right after reset.
// ----------------------------------------------------------------------------
module shunt_monitor_autorange #(
  parameter int HOLD_COUNT = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      in_bus_word,
  input  logic signed [15:0]               in_shunt_reading,
  input  logic signed [15:0]               in_hall_reading,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_current_value,
  output logic [12:0]                      out_bus_voltage,
  output logic                             out_config_write,
  output logic [7:0]                       out_config_high_byte,
  output logic [1:0]                       out_gain_code,
  output logic                             out_voltage_range_high,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [smar_pkg::CFG_DATA_W-1:0]  cfg_data
);

  smar_pkg::cfg_t     cfg_r;
  smar_pkg::in_beat_t in_beat;
  smar_pkg::in_beat_t s1_beat;
  smar_pkg::res_t     res;
  smar_pkg::res_t     out_res;
  logic               out_free;
  logic               fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_hall_current     <= 1'b0;
      cfg_r.current_switch_level <= smar_pkg::CURRENT_LEVEL_RST;
      cfg_r.voltage_switch_level <= smar_pkg::VOLTAGE_LEVEL_RST;
      cfg_r.voltage_offset       <= smar_pkg::VOLTAGE_OFS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        smar_pkg::REG_USE_HALL:      cfg_r.use_hall_current     <= cfg_data[0];
        smar_pkg::REG_CURRENT_LEVEL: cfg_r.current_switch_level <= cfg_data[14:0];
        smar_pkg::REG_VOLTAGE_LEVEL: cfg_r.voltage_switch_level <= cfg_data[12:0];
        smar_pkg::REG_VOLTAGE_OFS:   cfg_r.voltage_offset       <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign in_beat.bus_word      = in_bus_word;
  assign in_beat.shunt_reading = in_shunt_reading;
  assign in_beat.hall_reading  = in_hall_reading;

  smar_in u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_free (out_free),
    .fire     (fire),
    .s1_beat  (s1_beat)
  );

  smar_ctrl #(
    .HOLD_COUNT (HOLD_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .s1_beat (s1_beat),
    .cfg     (cfg_r),
    .res     (res)
  );

  smar_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_current_value      = out_res.current_value;
  assign out_bus_voltage        = out_res.bus_voltage;
  assign out_config_write       = out_res.config_write;
  assign out_config_high_byte   = out_res.config_high_byte;
  assign out_gain_code          = out_res.gain_code;
  assign out_voltage_range_high = out_res.voltage_range_high;

endmodule

### dv/tb_shunt_monitor_autorange.sv
// ----------------------------------------------------------------------------
// tb_shunt_monitor_autorange: self-checking bench for the shunt monitor
// A directed table covers the reset state, field extremes, the most negative
// shunt, a zero current level and every register. Random phases with new
// register settings follow, built mostly from long runs of low readings and
// short surges, so that gain and range step up and fall back. Every ready
// beat is predicted, and every result beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_shunt_monitor_autorange;

  localparam int HOLD         = 64;
  localparam int READINGS     = 1550;
  localparam int PHASES       = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;      // input and result registers plus margin
  localparam int GAP_PCT      = 21;
  localparam int GAIN_LSB     = 3;
  localparam logic [7:0] GAIN_BITS = 8'h18;
  localparam logic [7:0] RANGE_BIT = 8'h20;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         idx;
    logic [14:0]        data;
    smar_pkg::in_beat_t beat;
    logic               typed;
    smar_pkg::res_t     want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_bus_word = '0;
  logic signed [15:0] in_shunt_reading = '0;
  logic signed [15:0] in_hall_reading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_current_value;
  logic [12:0] out_bus_voltage;
  logic out_config_write;
  logic [7:0] out_config_high_byte;
  logic [1:0] out_gain_code;
  logic out_voltage_range_high;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [smar_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // tracked copy of the block's registers and control state
  logic        hall_sel;
  logic [14:0] cur_lvl;
  logic [12:0] volt_lvl;
  logic [12:0] volt_ofs;
  logic [1:0]  gain_lvl;
  int          gain_hold;
  logic        range_hi;
  int          range_hold;
  logic [7:0]  conf_hi;

  smar_pkg::res_t readings_due[$];
  plan_row_t      stim_plan[$];
  bit        steady = 1'b0;
  int        mismatches = 0;
  int        results_seen = 0;
  int        readings_fed = 0;
  int        ignored_fed = 0;
  int        cfg_writes = 0;
  int        cycle_count = 0;

  shunt_monitor_autorange #(.HOLD_COUNT(HOLD)) DUT (.*);

  always #5 clk = ~clk;

  always @(negedge clk) out_stall <= !steady && ($urandom_range(0, 99) < GAP_PCT);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycle_count,
               readings_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one shunt/bus sample through gain and range control
  task automatic track_reading(input smar_pkg::in_beat_t b, output logic fired,
                               output smar_pkg::res_t r);
    logic [12:0] volt;
    int mag;
    logic wr;
    fired = b.bus_word[smar_pkg::BUS_READY_BIT];
    r = '0;
    if (!fired) return;
    volt = b.bus_word[15:smar_pkg::BUS_VOLT_LSB];
    mag = (b.shunt_reading < 0) ? -int'(b.shunt_reading) : int'(b.shunt_reading);
    wr = 1'b0;
    if ((int'(cur_lvl) << gain_lvl) <= mag && gain_lvl < smar_pkg::GAIN_MAX) begin
      gain_lvl++;
      conf_hi = (conf_hi & ~GAIN_BITS) | (8'(gain_lvl) << GAIN_LSB);
      wr = 1'b1;
    end
    if (int'(cur_lvl) > mag) begin
      if (gain_hold > 0) begin
        gain_hold--;
        if (gain_hold == 0) begin
          conf_hi &= ~GAIN_BITS;
          gain_lvl = '0;
          wr = 1'b1;
        end
      end
    end else begin
      gain_hold = HOLD;
    end
    if (volt_lvl > volt) begin
      if (range_hold > 0) begin
        range_hold--;
        // falls back even when already on the low range
        if (range_hold == 0) begin
          conf_hi &= ~RANGE_BIT;
          range_hi = 1'b0;
          wr = 1'b1;
        end
      end
    end else begin
      range_hold = HOLD;
      if (!range_hi) begin
        range_hi = 1'b1;
        conf_hi |= RANGE_BIT;
        wr = 1'b1;
      end
    end
    r.current_value      = hall_sel ? b.hall_reading : -b.shunt_reading;
    r.bus_voltage        = (volt > volt_ofs) ? volt - volt_ofs : '0;
    r.config_write       = wr;
    r.config_high_byte   = conf_hi;
    r.gain_code          = gain_lvl;
    r.voltage_range_high = range_hi;
  endtask

  task automatic send_beat(input smar_pkg::in_beat_t b, input logic typed,
                           input smar_pkg::res_t want);
    logic fired;
    smar_pkg::res_t got;
    if (!steady && $urandom_range(0, 99) < GAP_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_bus_word      <= b.bus_word;
    in_shunt_reading <= b.shunt_reading;
    in_hall_reading  <= b.hall_reading;
    do @(posedge clk); while (in_stall);
    track_reading(b, fired, got);
    if (fired) begin
      readings_due.push_back(typed ? want : got);
      readings_fed++;
    end else begin
      ignored_fed++;
    end
  endtask

  // registers only change with nothing in flight
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      smar_pkg::REG_USE_HALL:      hall_sel = val[0];
      smar_pkg::REG_CURRENT_LEVEL: cur_lvl  = val;
      smar_pkg::REG_VOLTAGE_LEVEL: volt_lvl = val[12:0];
      smar_pkg::REG_VOLTAGE_OFS:   volt_ofs = val[12:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    smar_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        $display("%0t: result beat with none expected: current %0d voltage %0d", $time,
                 out_current_value, out_bus_voltage);
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        results_seen++;
        check_field("current_value", want.current_value, out_current_value);
        check_field("bus_voltage", want.bus_voltage, out_bus_voltage);
        check_field("config_write", want.config_write, out_config_write);
        check_field("config_high_byte", want.config_high_byte, out_config_high_byte);
        check_field("gain_code", want.gain_code, out_gain_code);
        check_field("voltage_range_high", want.voltage_range_high, out_voltage_range_high);
      end
    end
  end

  task automatic plan_beat(input logic [15:0] bus, input logic signed [15:0] shunt,
                           input logic signed [15:0] hall);
    plan_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.beat = '{bus, shunt, hall};
    stim_plan.push_back(row);
  endtask

  task automatic plan_typed(input logic [15:0] bus, input logic signed [15:0] shunt,
                            input logic signed [15:0] hall, input logic signed [15:0] cur,
                            input logic [12:0] volt, input logic wr, input logic [7:0] conf,
                            input logic [1:0] gain, input logic rng);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_BEAT;
    row.beat  = '{bus, shunt, hall};
    row.typed = 1'b1;
    row.want.current_value      = cur;
    row.want.bus_voltage        = volt;
    row.want.config_write       = wr;
    row.want.config_high_byte   = conf;
    row.want.gain_code          = gain;
    row.want.voltage_range_high = rng;
    stim_plan.push_back(row);
  endtask

  task automatic plan_cfg(input logic [1:0] idx, input logic [14:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = val;
    stim_plan.push_back(row);
  endtask

  function automatic smar_pkg::in_beat_t compose(input int volt, input int mag, input bit neg,
                                                 input bit ready);
    smar_pkg::in_beat_t b;
    b.bus_word = {13'(volt), 1'($urandom_range(0, 1)), ready, 1'($urandom_range(0, 1))};
    b.shunt_reading = neg ? 16'(-mag) : 16'((mag > 32767) ? 32767 : mag);
    b.hall_reading = 16'($urandom);
    return b;
  endfunction

  initial begin
    plan_row_t row;
    smar_pkg::in_beat_t b;
    logic [14:0] lvl;
    int phase, run_len, base_fed, mag, volt, target;

    hall_sel   = 1'b0;
    cur_lvl    = smar_pkg::CURRENT_LEVEL_RST;
    volt_lvl   = smar_pkg::VOLTAGE_LEVEL_RST;
    volt_ofs   = smar_pkg::VOLTAGE_OFS_RST;
    gain_lvl   = '0;
    gain_hold  = HOLD;
    range_hi   = 1'b0;
    range_hold = HOLD;
    conf_hi    = {smar_pkg::CONF_HIGH_BITS, 3'b000, smar_pkg::CONF_LOW_BITS};

    // bus, shunt, hall | current, voltage, write, conf byte, gain, range
    plan_typed(16'h0322, 16'sd100, 16'sh1234, -16'sd100, 13'd90, 1'b0, 8'h04, 2'd0, 1'b0);
    plan_beat(16'hFFFD, 16'sh7FFF, 16'sh8000);  // ready bit clear
    plan_typed(16'hFFFF, 16'sd0, 16'sh5555, 16'sd0, 13'd8181, 1'b1, 8'h24, 2'd0, 1'b1);
    // most negative shunt walks the gain to the top
    plan_typed(16'hFFFA, 16'sh8000, 16'shAAAA, 16'sh8000, 13'd8181, 1'b1, 8'h2C, 2'd1, 1'b1);
    plan_typed(16'h7FFE, 16'sh8000, 16'sh0001, 16'sh8000, 13'd4085, 1'b1, 8'h34, 2'd2, 1'b1);
    plan_typed(16'hFFFA, 16'sh8000, 16'sh0002, 16'sh8000, 13'd8181, 1'b1, 8'h3C, 2'd3, 1'b1);
    plan_typed(16'h0002, 16'sh8000, 16'sh0003, 16'sh8000, 13'd0, 1'b0, 8'h3C, 2'd3, 1'b1);
    plan_beat(16'h8002, 16'sd32000, 16'sh8000);
    plan_cfg(smar_pkg::REG_USE_HALL, 15'd1);
    plan_beat(16'h0002, 16'sd1, 16'sh8000);
    plan_beat(16'h0006, -16'sd1, 16'sh7FFF);
    plan_cfg(smar_pkg::REG_CURRENT_LEVEL, 15'd0);   // zero level: gain never falls back
    plan_beat(16'h0003, 16'sd0, 16'sh0000);
    plan_cfg(smar_pkg::REG_CURRENT_LEVEL, 15'h7FFF);
    plan_beat(16'h4002, 16'sh8000, 16'shFFFF);
    plan_cfg(smar_pkg::REG_VOLTAGE_LEVEL, 15'd0);
    plan_beat(16'h0002, 16'sd7, 16'sh0F0F);
    plan_cfg(smar_pkg::REG_VOLTAGE_LEVEL, 15'd8191);
    plan_beat(16'hFFFE, -16'sd32000, 16'shF0F0);
    plan_cfg(smar_pkg::REG_VOLTAGE_OFS, 15'd8191);
    plan_beat(16'hFFFF, 16'sd4000, 16'sh00FF);
    plan_cfg(smar_pkg::REG_VOLTAGE_OFS, 15'd0);
    plan_beat(16'hFFFB, -16'sd4000, 16'shFF00);
    plan_cfg(smar_pkg::REG_USE_HALL, 15'd0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_plan[i]) begin
      row = stim_plan[i];
      if (row.kind == ROW_CFG) write_reg(row.idx, row.data);
      else send_beat(row.beat, row.typed, row.want);
    end

    base_fed = readings_fed + ignored_fed;
    for (phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 3);
      write_reg(smar_pkg::REG_USE_HALL, 15'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0: lvl = 15'd1;
        1: lvl = 15'h7FFF;
        2: lvl = 15'd0;
        default: lvl = 15'($urandom_range(100, 6000));
      endcase
      write_reg(smar_pkg::REG_CURRENT_LEVEL, lvl);
      case ($urandom_range(0, 4))
        0: lvl = 15'd0;
        1: lvl = 15'd8191;
        default: lvl = 15'($urandom_range(100, 8000));
      endcase
      write_reg(smar_pkg::REG_VOLTAGE_LEVEL, lvl);
      case ($urandom_range(0, 4))
        0: lvl = 15'd0;
        1: lvl = 15'd8191;
        default: lvl = 15'($urandom_range(0, 300));
      endcase
      write_reg(smar_pkg::REG_VOLTAGE_OFS, lvl);

      target = (phase + 1) * READINGS / PHASES;
      while (readings_fed + ignored_fed - base_fed < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // quiet stretch, often long enough for the hold counters to run out
            run_len = $urandom_range(40, 90);
            repeat (run_len) begin
              if (readings_fed + ignored_fed - base_fed >= target) break;
              mag  = (cur_lvl == 0) ? 0 : $urandom_range(0, cur_lvl - 1);
              volt = (volt_lvl == 0) ? 0 : $urandom_range(0, volt_lvl - 1);
              b = compose(volt, mag, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
              send_beat(b, 1'b0, '0);
            end
          end
          5, 6, 7: begin
            run_len = $urandom_range(1, 8);
            repeat (run_len) begin
              if (readings_fed + ignored_fed - base_fed >= target) break;
              mag = $urandom_range(cur_lvl, 32768);
              b = compose($urandom_range(0, 8191), mag, 1'($urandom_range(0, 1)), 1'b1);
              send_beat(b, 1'b0, '0);
            end
          end
          default: begin
            run_len = $urandom_range(5, 30);
            repeat (run_len) begin
              if (readings_fed + ignored_fed - base_fed >= target) break;
              b.bus_word      = 16'($urandom);
              b.shunt_reading = 16'($urandom);
              b.hall_reading  = 16'($urandom);
              send_beat(b, 1'b0, '0);
            end
          end
        endcase
      end
    end
    steady = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d directed rows, %0d register writes, %0d ready and %0d ignored beats",
             stim_plan.size(), cfg_writes, readings_fed, ignored_fed);
    $display("%0d result beats compared, %0d mismatching fields", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/smar_pkg.sv
rtl/smar_in.sv
rtl/smar_ctrl.sv
rtl/smar_out.sv
rtl/shunt_monitor_autorange.sv
dv/tb_shunt_monitor_autorange.sv
